@@ hw/rtl/pli_pkg.sv @@
// Package: shared types and constants of the posting list intersection core
package pli_pkg;

    localparam int MAX_TERMS    = 4;
    localparam int MAX_POSTINGS = 1024;
    localparam int DOC_ID_BITS  = 20;
    localparam int TERM_BITS    = $clog2(MAX_TERMS);
    localparam int PTR_BITS     = $clog2(MAX_POSTINGS);
    localparam int LEN_BITS     = PTR_BITS + 1;
    localparam int ADDR_BITS    = TERM_BITS + PTR_BITS;
    localparam int WEIGHT_BITS  = 16;
    localparam int QUEUE_DEPTH  = 2;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_FETCH = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_MATCH     = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_EMPTY     = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]             cmd;
        logic [1:0]             term;
        logic [19:0]            doc_id;
        logic [WEIGHT_BITS-1:0] weight;
    } in_item_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [19:0]            match_doc;
        logic [WEIGHT_BITS-1:0] weight_0;
        logic [WEIGHT_BITS-1:0] weight_1;
        logic [WEIGHT_BITS-1:0] weight_2;
        logic [WEIGHT_BITS-1:0] weight_3;
    } out_item_t;

    // Classified operation handed from front to back
    typedef struct packed {
        logic                   is_load;
        logic                   is_fetch;
        logic                   is_clear;
        logic [TERM_BITS-1:0]   term;
        logic [DOC_ID_BITS-1:0] doc_id;
        logic [WEIGHT_BITS-1:0] weight;
    } op_t;

    // Queue handshake between front and back
    typedef struct packed {
        logic valid;
        logic ready;
    } link_t;

endpackage

@@ hw/rtl/posting_list_intersection_core.sv @@
// Top level: multiway posting list intersection core
//
//  channel  | signals                 | handshake
//  command  | start, busy, cmd_in     | taken when start && !busy
//  result   | done, result            | one-cycle strobe, cannot stall
//  config   | num_terms_we/_wdata     | written when num_terms_we
//
// Loads and clears are done by the back end in IDLE. A fetch goes from IDLE
// to DONE on an empty list; else READ and EVAL alternate, each advance one
// read-compare pair over the head banks, until a list runs out (READ to DONE)
// or a match is found (EVAL to DONE); DONE registers the result strobe.
// Reset clears list lengths, pointers and the exhaustion flag; stored
// postings stay undefined. busy rises while the two-entry command queue is full.
module posting_list_intersection_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  pli_pkg::in_item_t  cmd_in,
    output logic               done,
    output pli_pkg::out_item_t result,
    input  logic               num_terms_we,
    input  logic [2:0]         num_terms_wdata
);
    import pli_pkg::*;

    logic [2:0] num_terms_reg;
    logic       q_full, q_empty, q_pop, b_idle;
    op_t        q_head;

    // Hold the active term count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_terms_reg <= 3'd1;
        else if (num_terms_we)
            num_terms_reg <= num_terms_wdata;
    end

    assign busy = q_full;

    pli_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (cmd_in),
        .full  (q_full),
        .empty (q_empty),
        .pop   (q_pop),
        .head  (q_head)
    );

    pli_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_terms (num_terms_reg),
        .empty     (q_empty),
        .pop       (q_pop),
        .head      (q_head),
        .idle      (b_idle),
        .done      (done),
        .result    (result)
    );

`ifndef NO_ASSERTIONS
    // A result only leaves while the back end is not waiting idle
    a_done_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$past(b_idle)) else $error("result with idle back end");
    // Results are strobes, never two in a row
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe held");
    // Never pop an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty) else $error("pop from empty queue");
`endif
endmodule

@@ hw/rtl/pli_front.sv @@
// Front end: accepts commands, classifies them and queues them for the back end
module pli_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  pli_pkg::in_item_t item,
    output logic              full,
    output logic              empty,
    input  logic              pop,
    output pli_pkg::op_t      head
);
    import pli_pkg::*;

    localparam int QP = $clog2(QUEUE_DEPTH);

    op_t             q_reg [QUEUE_DEPTH];
    logic [QP-1:0]   wr_reg, rd_reg;
    logic [QP:0]     cnt_reg;
    op_t             op;
    logic            push;

    // Classify the incoming transaction; drop unknown commands and bad terms
    always_comb
    begin
        op = '0;
        op.term   = item.term[TERM_BITS-1:0];
        op.weight = item.weight;
        if (item.doc_id > 20'((64'd1 << DOC_ID_BITS) - 1))
            op.doc_id = DOC_ID_BITS'((64'd1 << DOC_ID_BITS) - 1);
        else
            op.doc_id = DOC_ID_BITS'(item.doc_id);
        case (item.cmd)
            CMD_LOAD:  op.is_load  = (32'(item.term) < MAX_TERMS);
            CMD_FETCH: op.is_fetch = 1'b1;
            CMD_CLEAR: op.is_clear = 1'b1;
            default:   op = '0;
        endcase
    end

    assign full  = (cnt_reg == (QP+1)'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign push  = start && !full && (op.is_load || op.is_fetch || op.is_clear);
    assign head  = q_reg[rd_reg];

    // Store payload
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= op;
    end

    // Advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (32'(wr_reg) == QUEUE_DEPTH-1) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (32'(rd_reg) == QUEUE_DEPTH-1) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (QP+1)'(push) - (QP+1)'(pop);
        end
    end
endmodule

@@ hw/rtl/pli_back.sv @@
// Back end: posting store, list pointers and the intersection walk
module pli_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [2:0]         num_terms,
    input  logic               empty,
    output logic               pop,
    input  pli_pkg::op_t       head,
    output logic               idle,
    output logic               done,
    output pli_pkg::out_item_t result
);
    import pli_pkg::*;

    localparam int DW = DOC_ID_BITS + WEIGHT_BITS;
    localparam int TB = $clog2(MAX_TERMS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EVAL = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    // One bank per term so every head is read in the same cycle
    logic [DW-1:0]        mem [MAX_TERMS][MAX_POSTINGS];
    logic [DW-1:0]        rdata_reg [MAX_TERMS];
    logic [LEN_BITS-1:0]  len_reg [MAX_TERMS];
    logic [LEN_BITS-1:0]  ptr_reg [MAX_TERMS];
    logic                 fin_reg;
    state_t               state_reg;
    out_item_t            res_reg;
    logic                 done_reg;
    logic [TB-1:0]        n;
    logic [MAX_TERMS-1:0] act, lempty, lend;
    logic                 same;
    logic [TERM_BITS-1:0] min_t;
    logic [DOC_ID_BITS-1:0] min_d;
    logic                 start_op;

    // Active term count clamped to range
    always_comb
    begin
        if (num_terms == 3'd0)
            n = TB'(1);
        else if (32'(num_terms) > MAX_TERMS)
            n = TB'(MAX_TERMS);
        else
            n = TB'(num_terms);
        for (int t = 0; t < MAX_TERMS; t++)
        begin
            act[t]    = (t < 32'(n));
            lempty[t] = act[t] && (len_reg[t] == '0);
            lend[t]   = act[t] && (ptr_reg[t] >= len_reg[t]);
        end
    end

    // Compare heads: smallest doc with lowest index on ties
    always_comb
    begin
        same  = 1'b1;
        min_t = '0;
        min_d = rdata_reg[0][DW-1:WEIGHT_BITS];
        for (int t = 1; t < MAX_TERMS; t++)
        begin
            if (act[t])
            begin
                if (rdata_reg[t][DW-1:WEIGHT_BITS] != rdata_reg[0][DW-1:WEIGHT_BITS])
                    same = 1'b0;
                if (rdata_reg[t][DW-1:WEIGHT_BITS] < min_d)
                begin
                    min_d = rdata_reg[t][DW-1:WEIGHT_BITS];
                    min_t = TERM_BITS'(t);
                end
            end
        end
    end

    assign start_op = (state_reg == S_IDLE) && !empty;
    assign pop      = start_op;
    assign idle     = (state_reg == S_IDLE) && empty;
    assign done     = done_reg;
    assign result   = res_reg;

    // Posting banks: write on load, read heads every cycle
    always_ff @(posedge clk)
    begin
        for (int t = 0; t < MAX_TERMS; t++)
        begin
            if (start_op && head.is_load && head.term == TERM_BITS'(t)
                && len_reg[t] < LEN_BITS'(MAX_POSTINGS))
                mem[t][len_reg[t][PTR_BITS-1:0]] <= {head.doc_id, head.weight};
            rdata_reg[t] <= mem[t][ptr_reg[t][PTR_BITS-1:0]];
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (start_op)
            res_reg <= (head.is_fetch && |lempty)
                       ? {ST_EMPTY, ($bits(out_item_t)-2)'(0)} : '0;
        if (state_reg == S_READ && (fin_reg || |lend))
            res_reg.status <= ST_EXHAUSTED;
        if (state_reg == S_EVAL && same)
        begin
            res_reg.status    <= ST_MATCH;
            res_reg.match_doc <= 20'(rdata_reg[0][DW-1:WEIGHT_BITS]);
            res_reg.weight_0  <= rdata_reg[0][WEIGHT_BITS-1:0];
            res_reg.weight_1  <= act[1] ? rdata_reg[1][WEIGHT_BITS-1:0] : '0;
            res_reg.weight_2  <= act[2] ? rdata_reg[2][WEIGHT_BITS-1:0] : '0;
            res_reg.weight_3  <= act[3] ? rdata_reg[3][WEIGHT_BITS-1:0] : '0;
        end
    end

    // Sequence the walk: READ checks ends and waits for head data, EVAL advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg   <= 1'b0;
            done_reg  <= 1'b0;
            for (int t = 0; t < MAX_TERMS; t++)
            begin
                len_reg[t] <= '0;
                ptr_reg[t] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start_op)
                    begin
                        if (head.is_clear)
                        begin
                            fin_reg <= 1'b0;
                            for (int t = 0; t < MAX_TERMS; t++)
                            begin
                                len_reg[t] <= '0;
                                ptr_reg[t] <= '0;
                            end
                        end
                        else if (head.is_load)
                        begin
                            for (int t = 0; t < MAX_TERMS; t++)
                                if (head.term == TERM_BITS'(t)
                                    && len_reg[t] < LEN_BITS'(MAX_POSTINGS))
                                    len_reg[t] <= len_reg[t] + 1'b1;
                        end
                        else if (head.is_fetch)
                        begin
                            if (|lempty)
                                state_reg <= S_DONE;
                            else
                                state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    if (fin_reg || |lend)
                    begin
                        fin_reg   <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (same)
                    begin
                        for (int t = 0; t < MAX_TERMS; t++)
                            if (act[t])
                                ptr_reg[t] <= ptr_reg[t] + 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        ptr_reg[min_t] <= ptr_reg[min_t] + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ verif/tb.sv @@
// Testbench for the posting list intersection core: scoreboard, stimulus and checks
`timescale 1ns / 1ps

class match_board;
    pli_pkg::out_item_t pending[$];
    int errors;
    int seen;

    // Per-list contents and walk state, mirrored from the block
    logic [19:0] docs[4][1024];
    logic [15:0] wts[4][1024];
    int lens[4];
    int ptrs[4];
    bit exhausted;
    logic [2:0] terms_reg;

    function void clear_all();
        for (int i = 0; i < 4; i++)
        begin
            lens[i] = 0;
            ptrs[i] = 0;
        end
        exhausted = 0;
    endfunction

    function void set_terms(logic [2:0] v);
        terms_reg = v;
    endfunction

    // Note an accepted transaction and compute what it yields
    function void note_input(pli_pkg::in_item_t it);
        pli_pkg::out_item_t r;
        int n;
        int mt;
        bit same;
        bit empty;
        if (it.cmd == pli_pkg::CMD_LOAD)
        begin
            if (lens[it.term] < 1024)
            begin
                docs[it.term][lens[it.term]] = it.doc_id;
                wts[it.term][lens[it.term]] = it.weight;
                lens[it.term]++;
            end
            return;
        end
        if (it.cmd == pli_pkg::CMD_CLEAR)
        begin
            clear_all();
            return;
        end
        if (it.cmd != pli_pkg::CMD_FETCH)
            return;
        r = '0;
        n = (terms_reg == 0) ? 1 : (terms_reg > 4 ? 4 : terms_reg);
        empty = 0;
        for (int t = 0; t < n; t++)
            if (lens[t] == 0)
                empty = 1;
        if (empty)
        begin
            r.status = pli_pkg::ST_EMPTY;
            pending = {pending, r};
            return;
        end
        forever
        begin
            for (int t = 0; t < n; t++)
                if (ptrs[t] >= lens[t])
                    exhausted = 1;
            if (exhausted)
            begin
                r.status = pli_pkg::ST_EXHAUSTED;
                break;
            end
            same = 1;
            mt = 0;
            for (int t = 1; t < n; t++)
            begin
                if (docs[t][ptrs[t]] != docs[0][ptrs[0]])
                    same = 0;
                if (docs[t][ptrs[t]] < docs[mt][ptrs[mt]])
                    mt = t;
            end
            if (same)
            begin
                r.status = pli_pkg::ST_MATCH;
                r.match_doc = docs[0][ptrs[0]];
                if (n > 0) r.weight_0 = wts[0][ptrs[0]];
                if (n > 1) r.weight_1 = wts[1][ptrs[1]];
                if (n > 2) r.weight_2 = wts[2][ptrs[2]];
                if (n > 3) r.weight_3 = wts[3][ptrs[3]];
                for (int t = 0; t < n; t++)
                    ptrs[t]++;
                break;
            end
            ptrs[mt]++;
        end
        pending = {pending, r};
    endfunction

    // Compare one result with the oldest expectation
    function void check_result(pli_pkg::out_item_t got);
        pli_pkg::out_item_t e;
        seen++;
        if (pending.size() == 0)
        begin
            $error("result with nothing expected: %h", got);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.status !== e.status)
        begin
            $error("status expected %0d actual %0d", e.status, got.status);
            errors++;
        end
        if (got.match_doc !== e.match_doc)
        begin
            $error("match_doc expected %0h actual %0h", e.match_doc, got.match_doc);
            errors++;
        end
        if (got.weight_0 !== e.weight_0)
        begin
            $error("weight_0 expected %0h actual %0h", e.weight_0, got.weight_0);
            errors++;
        end
        if (got.weight_1 !== e.weight_1)
        begin
            $error("weight_1 expected %0h actual %0h", e.weight_1, got.weight_1);
            errors++;
        end
        if (got.weight_2 !== e.weight_2)
        begin
            $error("weight_2 expected %0h actual %0h", e.weight_2, got.weight_2);
            errors++;
        end
        if (got.weight_3 !== e.weight_3)
        begin
            $error("weight_3 expected %0h actual %0h", e.weight_3, got.weight_3);
            errors++;
        end
    endfunction
endclass

module tb;
    import pli_pkg::*;

    // Command code the block must ignore
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_item_t cmd_in;
    logic done;
    out_item_t result;
    logic num_terms_we;
    logic [2:0] num_terms_wdata;

    match_board board;
    int idle_cycles = 0;
    int sent;
    int fetches;
    logic [19:0] next_doc[4];

    posting_list_intersection_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd_in(cmd_in),
        .done(done), .result(result), .num_terms_we(num_terms_we),
        .num_terms_wdata(num_terms_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Check every strobed result
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(result);
    end

    // Watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Send one command, with a random gap first
    task automatic send(logic [1:0] c, logic [1:0] tm, logic [19:0] d, logic [15:0] w);
        int gap;
        in_item_t it;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            start <= 1'b0;
            cmd_in <= 40'({$urandom, $urandom});
            repeat (gap) @(posedge clk);
        end
        it.cmd = c;
        it.term = tm;
        it.doc_id = d;
        it.weight = w;
        start <= 1'b1;
        cmd_in <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_input(it);
        if (it.cmd == CMD_FETCH) fetches++;
        sent++;
    endtask

    // Release the bus, wait for all results, then let the back end settle
    task automatic drain();
        start <= 1'b0;
        cmd_in <= 40'({$urandom, $urandom});
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_terms(logic [2:0] v);
        drain();
        num_terms_we <= 1'b1;
        num_terms_wdata <= v;
        @(posedge clk);
        num_terms_we <= 1'b0;
        board.set_terms(v);
    endtask

    // Fill lists with mostly ascending overlapping ids, then fetch len + 2 times and clear
    task automatic list_round(int len);
        int r;
        for (int t = 0; t < 4; t++)
            next_doc[t] = 20'($urandom_range(0, 8));
        for (int i = 0; i < len * 4; i++)
        begin
            r = $urandom_range(0, 3);
            next_doc[r] = 20'(next_doc[r] + $urandom_range(0, 3));
            if ($urandom_range(0, 15) == 0)
                send(CMD_LOAD, r[1:0], 20'($urandom), 16'($urandom));
            else
                send(CMD_LOAD, r[1:0], next_doc[r], 16'($urandom));
            if ($urandom_range(0, 9) == 0)
                send(CMD_FETCH, 2'($urandom), 20'($urandom), 16'($urandom));
        end
        for (int i = 0; i < len + 2; i++)
            send(CMD_FETCH, 2'($urandom), 20'($urandom), 16'($urandom));
        if ($urandom_range(0, 7) == 0)
            send(CMD_RESERVED, 2'($urandom), 20'($urandom), 16'($urandom));
        send(CMD_CLEAR, 2'($urandom), 20'($urandom), 16'($urandom));
    endtask

    initial
    begin
        board = new();
        board.clear_all();
        board.set_terms(3'd1);
        rst_n = 1'b0;
        start = 1'b0;
        cmd_in = '0;
        num_terms_we = 1'b0;
        num_terms_wdata = 3'd0;
        sent = 0;
        fetches = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty fetch, extremes, unknown command, exhaustion
        send(CMD_FETCH, 2'd0, 20'd0, 16'd0);
        send(CMD_LOAD, 2'd0, 20'd0, 16'd0);
        send(CMD_LOAD, 2'd0, 20'hFFFFF, 16'hFFFF);
        send(CMD_RESERVED, 2'd3, 20'hFFFFF, 16'hFFFF);
        send(CMD_FETCH, 2'd0, 20'd0, 16'd0);
        send(CMD_FETCH, 2'd0, 20'd0, 16'd0);
        send(CMD_FETCH, 2'd0, 20'd0, 16'd0);
        send(CMD_LOAD, 2'd0, 20'd5, 16'd1);
        send(CMD_FETCH, 2'd0, 20'd0, 16'd0);
        send(CMD_CLEAR, 2'd0, 20'd0, 16'd0);
        write_terms(3'd4);
        send(CMD_LOAD, 2'd3, 20'd7, 16'h0100);
        send(CMD_FETCH, 2'd0, 20'd0, 16'd0);
        for (int t = 0; t < 3; t++)
            send(CMD_LOAD, t[1:0], 20'd7, 16'h8000 >> t);
        send(CMD_FETCH, 2'd0, 20'd0, 16'd0);
        send(CMD_FETCH, 2'd0, 20'd0, 16'd0);
        send(CMD_CLEAR, 2'd0, 20'd0, 16'd0);

        // Full list: overflow load is dropped
        write_terms(3'd1);
        for (int i = 0; i < 1025; i++)
            send(CMD_LOAD, 2'd0, i[19:0], i[15:0]);
        drain();
        for (int i = 0; i < 3; i++)
            send(CMD_FETCH, 2'd0, 20'd0, 16'd0);
        send(CMD_CLEAR, 2'd0, 20'd0, 16'd0);

        // Random rounds over random term settings, out-of-range ones too
        while (sent < 1600)
        begin
            write_terms(3'($urandom_range(0, 7)));
            list_round($urandom_range(1, 12));
        end
        write_terms(3'd4);
        list_round(10);
        drain();

        $display("Sent %0d transactions, %0d fetches; %0d results checked.",
                 sent, fetches, board.seen);
        $display("Covered empty, exhausted, overflow and all term counts 0..7.");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
